// ===== rtl/limit_order_book_matcher_defines.svh =====
// Assertion macros for the limit order book matcher checker.
// No dependencies.
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define LOB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lob check failed");

// next-cycle implication
`define LOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lob check failed");

`endif

// ===== rtl/lob_pkg.sv =====
// Shared types and constants for the limit order book matcher.
// No dependencies.
`default_nettype none
package lob_pkg;
  localparam int unsigned LOB_PRICE_LEVELS   = 256;
  localparam int unsigned LOB_LEVEL_QTY_BITS = 24;
  localparam int unsigned LOB_ORD_QTY_BITS   = 16;
  localparam int unsigned LOB_PRICE_BITS     = 8;
  localparam int unsigned LOB_TOP_QTY_BITS   = 24;

  typedef enum logic {
    LOB_OP_MATCH = 1'b0,
    LOB_OP_REST  = 1'b1
  } lob_op_e;

  typedef struct packed {
    logic sat;
    logic lvl_zero;
  } lob_alu_st_t;
endpackage
`default_nettype wire

// ===== rtl/lob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lob_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/lob_alu.sv =====
// Shared level arithmetic: match (min and subtract) or rest (saturating add).
// Depends on lob_pkg.
`default_nettype none
module lob_alu #(
  parameter int unsigned LQ = 24
) (
  input  lob_pkg::lob_op_e     op_i,
  input  wire logic [LQ-1:0]   lvl_i,
  input  wire logic [15:0]     rem_i,
  output logic      [LQ-1:0]   lvl_o,
  output logic      [15:0]     rem_o,
  output logic      [15:0]     fill_o,
  output lob_pkg::lob_alu_st_t st_o
);
  import lob_pkg::*;

  logic [LQ-1:0] rem_ext;
  logic [LQ-1:0] take;
  logic [LQ:0]   sum;

  always_comb begin
    rem_ext = LQ'(rem_i);
    take    = (lvl_i < rem_ext) ? lvl_i : rem_ext;
    sum     = (LQ+1)'(lvl_i) + (LQ+1)'(rem_i);
    st_o.sat = 1'b0;
    unique case (op_i)
      LOB_OP_MATCH: begin
        fill_o = 16'(take);
        lvl_o  = lvl_i - take;
        rem_o  = rem_i - 16'(take);
      end
      LOB_OP_REST: begin
        fill_o   = '0;
        rem_o    = rem_i;
        st_o.sat = sum[LQ];
        lvl_o    = sum[LQ] ? {LQ{1'b1}} : sum[LQ-1:0];
      end
      default: begin
        fill_o = '0;
        rem_o  = rem_i;
        lvl_o  = lvl_i;
      end
    endcase
    st_o.lvl_zero = (lvl_o == '0);
  end
endmodule
`default_nettype wire

// ===== rtl/limit_order_book_matcher.sv =====
// Limit order book matcher top level: sequencer, level RAMs and shared ALU.
// Depends on lob_pkg, lob_ram, lob_alu.
//
//  channel   handshake          payload
//  order     start_i / busy_o   order_side_i, price_tick_i, order_qty_i
//  result    done_o (1 cycle)   filled_qty_o .. level_saturated_o
//
// An item is taken when start_i is high and busy_o low. The sequencer walks
// the opposite side one price level at a time (RAM read, then match and
// write back), starting at the best level and scanning on to the next level
// that holds quantity; no level is visited when the other side is empty.
// busy_o stays high through the walk, any rest and the top-of-book read;
// done_o pulses in the cycle busy_o drops. After reset a clearing pass zeroes
// both RAMs level by level with busy_o high. The result shows for one cycle on
// done_o; the receiver cannot stall.
`default_nettype none
module limit_order_book_matcher #(
  parameter int unsigned PRICE_LEVELS   = lob_pkg::LOB_PRICE_LEVELS,
  parameter int unsigned LEVEL_QTY_BITS = lob_pkg::LOB_LEVEL_QTY_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        order_side_i,
  input  wire logic [7:0]  price_tick_i,
  input  wire logic [15:0] order_qty_i,
  output logic             done_o,
  output logic [15:0]      filled_qty_o,
  output logic [15:0]      rested_qty_o,
  output logic             bid_empty_o,
  output logic [7:0]       top_bid_price_o,
  output logic [23:0]      top_bid_qty_o,
  output logic             ask_empty_o,
  output logic [7:0]       top_ask_price_o,
  output logic [23:0]      top_ask_qty_o,
  output logic             level_saturated_o
);
  import lob_pkg::*;

  localparam int unsigned IW = $clog2(PRICE_LEVELS);
  localparam int unsigned LQ = LEVEL_QTY_BITS;
  localparam logic [IW-1:0] LAST = IW'(PRICE_LEVELS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WALK_RD, ST_WALK_EX, ST_REST_RD, ST_REST_EX, ST_TOP_RD, ST_TOP_EX
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] price_q, price_d;
  logic          side_q, side_d;     // 1 = sell
  logic [15:0]   rem_q, rem_d;
  logic [15:0]   filled_q, filled_d;
  logic          sat_q, sat_d;
  logic [IW-1:0] best_bid_q, best_bid_d, best_ask_q, best_ask_d;
  logic          bid_ne_q, bid_ne_d, ask_ne_q, ask_ne_d;
  logic          done_d;
  logic [15:0]   filled_o_d, rested_o_d;
  logic          bid_empty_d, ask_empty_d, lvl_sat_d;
  logic [7:0]    top_bid_price_d, top_ask_price_d;
  logic [23:0]   top_bid_qty_d, top_ask_qty_d;

  // RAM ports
  logic          bid_we, ask_we;
  logic [IW-1:0] bid_waddr, ask_waddr, bid_raddr, ask_raddr;
  logic [LQ-1:0] bid_wdata, ask_wdata, bid_rdata, ask_rdata;

  // ALU
  lob_op_e       alu_op;
  logic [LQ-1:0] alu_lvl_in, alu_lvl;
  logic [15:0]   alu_rem, alu_fill;
  lob_alu_st_t   alu_st;

  logic          rest_phase, sel_bid, in_rng, take, nz, at_end;
  logic [IW-1:0] price_in;

  lob_ram #(.WIDTH(LQ), .DEPTH(PRICE_LEVELS)) u_bid_ram (
    .clk_i, .we_i(bid_we), .waddr_i(bid_waddr), .wdata_i(bid_wdata),
    .raddr_i(bid_raddr), .rdata_o(bid_rdata)
  );

  lob_ram #(.WIDTH(LQ), .DEPTH(PRICE_LEVELS)) u_ask_ram (
    .clk_i, .we_i(ask_we), .waddr_i(ask_waddr), .wdata_i(ask_wdata),
    .raddr_i(ask_raddr), .rdata_o(ask_rdata)
  );

  lob_alu #(.LQ(LQ)) u_alu (
    .op_i(alu_op), .lvl_i(alu_lvl_in), .rem_i(rem_q),
    .lvl_o(alu_lvl), .rem_o(alu_rem), .fill_o(alu_fill), .st_o(alu_st)
  );

  // walk side is the opposite book; rest side is the order's own book
  assign rest_phase = (state_q == ST_REST_EX);
  assign sel_bid    = side_q ^ rest_phase;
  assign alu_lvl_in = sel_bid ? bid_rdata : ask_rdata;
  assign alu_op     = rest_phase ? LOB_OP_REST : LOB_OP_MATCH;
  assign in_rng     = side_q ? (idx_q >= price_q) : (idx_q <= price_q);
  assign take       = in_rng && (rem_q != '0);
  assign nz         = take ? !alu_st.lvl_zero : (alu_lvl_in != '0);
  assign at_end     = side_q ? (idx_q == '0) : (idx_q == LAST);
  assign price_in   = (32'(price_tick_i) >= PRICE_LEVELS) ? LAST : IW'(price_tick_i);

  assign bid_raddr = (state_q == ST_TOP_RD) ? best_bid_q :
                     (state_q == ST_REST_RD) ? price_q : idx_q;
  assign ask_raddr = (state_q == ST_TOP_RD) ? best_ask_q :
                     (state_q == ST_REST_RD) ? price_q : idx_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    price_d  = price_q;
    side_d   = side_q;
    rem_d    = rem_q;
    filled_d = filled_q;
    sat_d    = sat_q;
    best_bid_d = best_bid_q;
    best_ask_d = best_ask_q;
    bid_ne_d   = bid_ne_q;
    ask_ne_d   = ask_ne_q;
    done_d     = 1'b0;
    filled_o_d = filled_qty_o;
    rested_o_d = rested_qty_o;
    bid_empty_d = bid_empty_o;
    ask_empty_d = ask_empty_o;
    lvl_sat_d   = level_saturated_o;
    top_bid_price_d = top_bid_price_o;
    top_ask_price_d = top_ask_price_o;
    top_bid_qty_d   = top_bid_qty_o;
    top_ask_qty_d   = top_ask_qty_o;
    bid_we = 1'b0;
    ask_we = 1'b0;
    bid_waddr = idx_q;
    ask_waddr = idx_q;
    bid_wdata = alu_lvl;
    ask_wdata = alu_lvl;

    unique case (state_q)
      ST_CLEAR: begin
        bid_we    = 1'b1;
        ask_we    = 1'b1;
        bid_wdata = '0;
        ask_wdata = '0;
        idx_d     = idx_q + 1'b1;
        if (idx_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          side_d   = order_side_i;
          price_d  = price_in;
          rem_d    = order_qty_i;
          filled_d = '0;
          sat_d    = 1'b0;
          idx_d    = order_side_i ? best_bid_q : best_ask_q;
          if (order_side_i ? bid_ne_q : ask_ne_q) begin
            state_d = ST_WALK_RD;
          end else if (order_qty_i != '0) begin
            state_d = ST_REST_RD;
          end else begin
            state_d = ST_TOP_RD;
          end
        end
      end
      ST_WALK_RD: state_d = ST_WALK_EX;
      ST_WALK_EX: begin
        if (take) begin
          bid_we   = side_q;
          ask_we   = !side_q;
          rem_d    = alu_rem;
          filled_d = filled_q + alu_fill;
        end
        if (nz || at_end) begin
          // walk over: record new best level of the opposite side
          if (side_q) begin
            bid_ne_d   = nz;
            best_bid_d = nz ? idx_q : '0;
          end else begin
            ask_ne_d   = nz;
            best_ask_d = nz ? idx_q : '0;
          end
          state_d = ((take ? alu_rem : rem_q) != '0) ? ST_REST_RD : ST_TOP_RD;
        end else begin
          idx_d   = side_q ? idx_q - 1'b1 : idx_q + 1'b1;
          state_d = ST_WALK_RD;
        end
      end
      ST_REST_RD: state_d = ST_REST_EX;
      ST_REST_EX: begin
        bid_waddr = price_q;
        ask_waddr = price_q;
        bid_we    = !side_q;
        ask_we    = side_q;
        sat_d     = alu_st.sat;
        if (side_q) begin
          if (!ask_ne_q || (price_q < best_ask_q)) begin
            best_ask_d = price_q;
          end
          ask_ne_d = 1'b1;
        end else begin
          if (!bid_ne_q || (price_q > best_bid_q)) begin
            best_bid_d = price_q;
          end
          bid_ne_d = 1'b1;
        end
        state_d = ST_TOP_RD;
      end
      ST_TOP_RD: state_d = ST_TOP_EX;
      ST_TOP_EX: begin
        done_d      = 1'b1;
        filled_o_d  = filled_q;
        rested_o_d  = rem_q;
        lvl_sat_d   = sat_q;
        bid_empty_d = !bid_ne_q;
        ask_empty_d = !ask_ne_q;
        top_bid_price_d = bid_ne_q ? 8'(best_bid_q) : '0;
        top_ask_price_d = ask_ne_q ? 8'(best_ask_q) : '0;
        top_bid_qty_d = !bid_ne_q ? '0 :
          (33'(bid_rdata) > 33'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(bid_rdata);
        top_ask_qty_d = !ask_ne_q ? '0 :
          (33'(ask_rdata) > 33'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(ask_rdata);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      idx_q      <= '0;
      price_q    <= '0;
      side_q     <= 1'b0;
      rem_q      <= '0;
      filled_q   <= '0;
      sat_q      <= 1'b0;
      best_bid_q <= '0;
      best_ask_q <= '0;
      bid_ne_q   <= 1'b0;
      ask_ne_q   <= 1'b0;
      done_o     <= 1'b0;
      filled_qty_o      <= '0;
      rested_qty_o      <= '0;
      bid_empty_o       <= 1'b1;
      ask_empty_o       <= 1'b1;
      level_saturated_o <= 1'b0;
      top_bid_price_o   <= '0;
      top_ask_price_o   <= '0;
      top_bid_qty_o     <= '0;
      top_ask_qty_o     <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      price_q    <= price_d;
      side_q     <= side_d;
      rem_q      <= rem_d;
      filled_q   <= filled_d;
      sat_q      <= sat_d;
      best_bid_q <= best_bid_d;
      best_ask_q <= best_ask_d;
      bid_ne_q   <= bid_ne_d;
      ask_ne_q   <= ask_ne_d;
      done_o     <= done_d;
      filled_qty_o      <= filled_o_d;
      rested_qty_o      <= rested_o_d;
      bid_empty_o       <= bid_empty_d;
      ask_empty_o       <= ask_empty_d;
      level_saturated_o <= lvl_sat_d;
      top_bid_price_o   <= top_bid_price_d;
      top_ask_price_o   <= top_ask_price_d;
      top_bid_qty_o     <= top_bid_qty_d;
      top_ask_qty_o     <= top_ask_qty_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/lob_checker.sv =====
// Port-level checks for the limit order book matcher, bound to the top level.
// Depends on limit_order_book_matcher_defines.svh.
`default_nettype none
`include "limit_order_book_matcher_defines.svh"
module lob_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        bid_empty_o,
  input wire logic [7:0]  top_bid_price_o,
  input wire logic [23:0] top_bid_qty_o,
  input wire logic        ask_empty_o,
  input wire logic [7:0]  top_ask_price_o,
  input wire logic [23:0] top_ask_qty_o
);
  // a result only ends a busy stretch
  `LOB_ASSERT_SAME(a_done_after_busy, done_o, !busy_o && $past(busy_o))
  `LOB_ASSERT_NEXT(a_done_single, done_o, !done_o)
  // an accepted item always makes the block busy
  `LOB_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `LOB_ASSERT_SAME(a_bid_empty_zero, done_o && bid_empty_o,
                   top_bid_price_o == 8'd0 && top_bid_qty_o == 24'd0)
  `LOB_ASSERT_SAME(a_ask_nonempty_qty, done_o && !ask_empty_o, top_ask_qty_o != 24'd0)
endmodule

bind limit_order_book_matcher lob_checker u_lob_checker (.*);
`default_nettype wire

// ===== bench/tb_limit_order_book_matcher.sv =====
// Self-checking bench for limit_order_book_matcher: random and directed orders,
// each result checked against a behavioral book model kept in the bench.
// Depends on lob_pkg and the matcher RTL.
`default_nettype none
module tb_limit_order_book_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import lob_pkg::*;

  localparam int unsigned LEVEL_MAX  = (1 << LOB_LEVEL_QTY_BITS) - 1;
  // sized for a worst walk that visits every level, plus margin
  localparam int unsigned DRAIN_WAIT = 2 * LOB_PRICE_LEVELS + 100;

  typedef struct {
    logic        side;
    logic [7:0]  price;
    logic [15:0] qty;
  } order_t;

  typedef struct {
    logic [15:0] filled;
    logic [15:0] rested;
    logic        bid_empty;
    logic [7:0]  bid_tick;
    logic [23:0] bid_qty;
    logic        ask_empty;
    logic [7:0]  ask_tick;
    logic [23:0] ask_qty;
    logic        sat;
  } fill_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        order_side_i = 1'b0;
  logic [7:0]  price_tick_i = '0;
  logic [15:0] order_qty_i = '0;
  logic        busy_o, done_o, bid_empty_o, ask_empty_o, level_saturated_o;
  logic [15:0] filled_qty_o, rested_qty_o;
  logic [7:0]  top_bid_price_o, top_ask_price_o;
  logic [23:0] top_bid_qty_o, top_ask_qty_o;

  limit_order_book_matcher i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .order_side_i, .price_tick_i, .order_qty_i,
    .done_o, .filled_qty_o, .rested_qty_o, .bid_empty_o, .top_bid_price_o,
    .top_bid_qty_o, .ask_empty_o, .top_ask_price_o, .top_ask_qty_o,
    .level_saturated_o
  );

  // bench copy of the book, one aggregate per level and side
  int unsigned bid_book[LOB_PRICE_LEVELS];
  int unsigned ask_book[LOB_PRICE_LEVELS];

  order_t       stim_q[$];         // items waiting to be driven
  fill_report_t pending_fills[$];  // predicted results, oldest first
  int unsigned  taken_count = 0;   // bumped at each accepted item
  int unsigned  sender_idle_pct = 0;
  int unsigned  error_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Walks the opposite side, rests the remainder, then rescans the top of book.
  task automatic match_order(input order_t o, output fill_report_t r);
    int unsigned rem, filled, take, sum;
    int i;
    rem = o.qty;
    filled = 0;
    r.sat = 1'b0;
    if (!o.side) begin
      for (i = 0; i <= int'(o.price) && rem != 0; i++) begin
        take = (rem < ask_book[i]) ? rem : ask_book[i];
        ask_book[i] -= take;
        rem -= take;
        filled += take;
      end
    end else begin
      for (i = LOB_PRICE_LEVELS - 1; i >= int'(o.price) && rem != 0; i--) begin
        take = (rem < bid_book[i]) ? rem : bid_book[i];
        bid_book[i] -= take;
        rem -= take;
        filled += take;
      end
    end
    if (rem != 0) begin
      sum = o.side ? ask_book[o.price] + rem : bid_book[o.price] + rem;
      if (sum > LEVEL_MAX) begin
        sum = LEVEL_MAX;
        r.sat = 1'b1;
      end
      if (o.side) ask_book[o.price] = sum;
      else bid_book[o.price] = sum;
    end
    r.filled = filled[15:0];
    r.rested = rem[15:0];
    r.bid_empty = 1'b1;
    r.bid_tick = '0;
    r.bid_qty = '0;
    for (i = LOB_PRICE_LEVELS - 1; i >= 0 && r.bid_empty; i--) begin
      if (bid_book[i] != 0) begin
        r.bid_empty = 1'b0;
        r.bid_tick = i[7:0];
        r.bid_qty = bid_book[i][23:0];
      end
    end
    r.ask_empty = 1'b1;
    r.ask_tick = '0;
    r.ask_qty = '0;
    for (i = 0; i < LOB_PRICE_LEVELS && r.ask_empty; i++) begin
      if (ask_book[i] != 0) begin
        r.ask_empty = 1'b0;
        r.ask_tick = i[7:0];
        r.ask_qty = ask_book[i][23:0];
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: hold an item until taken, otherwise present the next one or idle.
  always @(negedge clk_i) begin
    static int unsigned seen_count = 0;
    if (!(start_i && taken_count == seen_count)) begin
      if (rst_ni && stim_q.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        order_side_i <= stim_q[0].side;
        price_tick_i <= stim_q[0].price;
        order_qty_i  <= stim_q[0].qty;
        start_i      <= 1'b1;
        seen_count = taken_count;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check the result first, then predict for an item taken this edge.
  always @(posedge clk_i) begin
    fill_report_t want, got;
    order_t o;
    if (rst_ni && done_o) begin
      got = '{filled_qty_o, rested_qty_o, bid_empty_o, top_bid_price_o, top_bid_qty_o,
              ask_empty_o, top_ask_price_o, top_ask_qty_o, level_saturated_o};
      if (pending_fills.size() == 0) begin
        $display("%0t unexpected result", $realtime);
        error_count++;
      end else begin
        want = pending_fills.pop_front();
        if (got.filled !== want.filled) report_mismatch("filled_qty", got.filled, want.filled);
        if (got.rested !== want.rested) report_mismatch("rested_qty", got.rested, want.rested);
        if (got.bid_empty !== want.bid_empty)
          report_mismatch("bid_empty", got.bid_empty, want.bid_empty);
        if (got.bid_tick !== want.bid_tick)
          report_mismatch("top_bid_price", got.bid_tick, want.bid_tick);
        if (got.bid_qty !== want.bid_qty)
          report_mismatch("top_bid_qty", got.bid_qty, want.bid_qty);
        if (got.ask_empty !== want.ask_empty)
          report_mismatch("ask_empty", got.ask_empty, want.ask_empty);
        if (got.ask_tick !== want.ask_tick)
          report_mismatch("top_ask_price", got.ask_tick, want.ask_tick);
        if (got.ask_qty !== want.ask_qty)
          report_mismatch("top_ask_qty", got.ask_qty, want.ask_qty);
        if (got.sat !== want.sat) report_mismatch("level_saturated", got.sat, want.sat);
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      o = '{order_side_i, price_tick_i, order_qty_i};
      void'(stim_q.pop_front());
      match_order(o, want);
      pending_fills = {pending_fills, want};
      taken_count++;
    end
  end

  // Prices cluster near mid book so orders cross and sweep several levels.
  function automatic order_t rand_order();
    order_t o;
    int unsigned pick;
    o.side = 1'($urandom_range(1));
    o.price = ($urandom_range(99) < 70) ? 8'($urandom_range(143, 112)) :
                                          8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) o.qty = 16'($urandom_range(500, 1));
    else if (pick < 80) o.qty = 16'($urandom_range(5000, 1));
    else if (pick < 95) o.qty = 16'($urandom);
    else o.qty = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return o;
  endfunction

  task automatic push_order(input logic side, input int unsigned price,
                            input int unsigned qty);
    order_t o;
    o = '{side, price[7:0], qty[15:0]};
    stim_q = {stim_q, o};
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || pending_fills.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned n);
    sender_idle_pct = idle_pct;
    repeat (n) stim_q = {stim_q, rand_order()};
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero qty, book edges, multi-level sweeps, emptied book
    push_order(1'b0, 10, 0);
    push_order(1'b1, 200, 0);
    push_order(1'b0, 0, 100);
    push_order(1'b0, 255, 16'hFFFF);
    push_order(1'b1, 255, 1);
    push_order(1'b1, 0, 16'hFFFF);
    push_order(1'b1, 50, 300);
    push_order(1'b1, 60, 300);
    push_order(1'b1, 70, 300);
    push_order(1'b0, 65, 450);
    push_order(1'b0, 255, 2000);
    push_order(1'b1, 0, 16'hFFFF);
    push_order(1'b0, 0, 16'hFFFF);
    push_order(1'b1, 255, 7);
    push_order(1'b0, 128, 1);
    wait_drained();

    random_phase(0, 400);
    random_phase(53, 400);
    random_phase(17, 400);

    // pile full-size buys on one level until it clips, then take some back
    sender_idle_pct = 0;
    repeat (262) push_order(1'b0, 3, 16'hFFFF);
    repeat (6) push_order(1'b1, 3, 16'hFFFF);
    wait_drained();

    // batches of ten; the sender waits until the block has answered every item of a batch
    repeat (18) begin
      sender_idle_pct = 17;
      repeat (10) stim_q = {stim_q, rand_order()};
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog; this allows several times the slowest run
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
